>>> hdl/hdd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdd_pkg
// Shared widths and handshake structs for the base-n digit distance core.
// ----------------------------------------------------------------------------
package hdd_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned DIST_W = 6;
	localparam int unsigned CNT_W  = $clog2(DATA_W);

	localparam logic [DATA_W-1:0] RADIX_RESET = DATA_W'(10);
	localparam logic [DATA_W-1:0] RADIX_MIN   = DATA_W'(2);

	// request into the shared divider
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	// response from the shared divider
	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
		logic [DATA_W-1:0] remainder;
	} div_rsp_t;

endpackage
`default_nettype wire

>>> hdl/hdd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdd_in_if
// Operand channel: two unsigned values per beat.
// ----------------------------------------------------------------------------
interface hdd_in_if
	import hdd_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] first_value;
	logic [DATA_W-1:0] second_value;

	modport source (output valid, output first_value, output second_value, input ready);
	modport sink (input valid, input first_value, input second_value, output ready);
endinterface
`default_nettype wire

>>> hdl/hdd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdd_out_if
// Result channel: digit distance and radix error flag per beat.
// ----------------------------------------------------------------------------
interface hdd_out_if
	import hdd_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;
	logic              bad_radix;

	modport source (output valid, output distance, output bad_radix, input ready);
	modport sink (input valid, input distance, input bad_radix, output ready);
endinterface
`default_nettype wire

>>> hdl/hdd_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdd_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hdd_divider
	import hdd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvs_q;

	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;

	assign trial = {rem_q, quo_q[DATA_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == CNT_W'(DATA_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top bit drops after a subtract
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
			end else begin
				rem_q <= trial[DATA_W-1:0];
			end
			quo_q <= {quo_q[DATA_W-2:0], ~diff[DATA_W]};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule
`default_nettype wire

>>> hdl/base_n_digit_hamming_distance_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base_n_digit_hamming_distance_core
// Counts digit positions, in a programmable radix, where two values differ.
// ----------------------------------------------------------------------------
//  channel     dir  handshake       payload
//  operands    in   valid / ready   first_value[31:0], second_value[31:0]
//  result      out  valid / ready   distance[5:0], bad_radix
//  radix_*     in   radix_we        radix_wdata[31:0]
//
//  one operand beat at a time; ready only while the sequencer is idle
//  each digit position runs two divides on the shared divider, first value then
//  second, for up to 32 positions
//  a radix below two skips the divides and finishes with bad_radix set
//  result sits in an output register; a new operand beat is taken while it waits
//  reset sets radix to 10 and clears all handshake state
// ----------------------------------------------------------------------------
module base_n_digit_hamming_distance_core
	import hdd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              radix_we,
	input  wire logic [DATA_W-1:0] radix_wdata,
	hdd_in_if.sink                 operands,
	hdd_out_if.source              result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_A,
		ST_DIV_B,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [DATA_W-1:0] radix_q;
	logic [DATA_W-1:0] a_q;
	logic [DATA_W-1:0] b_q;
	logic [DATA_W-1:0] qa_q;
	logic [DATA_W-1:0] ra_q;
	logic [DIST_W-1:0] count_q;
	logic              bad_q;
	logic              div_start_q;
	logic [DATA_W-1:0] div_dvd_q;
	logic              out_valid_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              out_bad_q;

	div_req_t          div_req;
	div_rsp_t          div_rsp;
	logic              in_beat;
	logic              out_free;
	logic              differ;
	logic              div_go;

	assign in_beat  = operands.valid && operands.ready;
	assign out_free = !out_valid_q || result.ready;

	// a position differs if only one side still has magnitude, else compare digits
	assign differ = ((a_q != '0) != (b_q != '0)) || (ra_q != div_rsp.remainder);

	// kick the divider for the first value of a position, then for the second
	assign div_go = ((state_q == ST_CHECK) && (a_q != '0 || b_q != '0)) ||
		((state_q == ST_DIV_A) && div_rsp.done);

	assign div_req.start    = div_start_q;
	assign div_req.dividend = div_dvd_q;
	assign div_req.divisor  = radix_q;

	hdd_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= RADIX_RESET;
			state_q     <= ST_IDLE;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			bad_q       <= 1'b0;
			a_q         <= '0;
			b_q         <= '0;
			qa_q        <= '0;
			ra_q        <= '0;
			div_dvd_q   <= '0;
			out_dist_q  <= '0;
			out_bad_q   <= 1'b0;
		end else begin
			div_start_q <= div_go;
			if (radix_we) begin
				radix_q <= radix_wdata;
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						a_q     <= operands.first_value;
						b_q     <= operands.second_value;
						count_q <= '0;
						if (radix_q < RADIX_MIN) begin
							bad_q   <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							bad_q   <= 1'b0;
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (a_q == '0 && b_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						div_dvd_q <= a_q;
						state_q   <= ST_DIV_A;
					end
				end
				ST_DIV_A: begin
					if (div_rsp.done) begin
						qa_q      <= div_rsp.quotient;
						ra_q      <= div_rsp.remainder;
						div_dvd_q <= b_q;
						state_q   <= ST_DIV_B;
					end
				end
				ST_DIV_B: begin
					if (div_rsp.done) begin
						if (differ) begin
							count_q <= count_q + DIST_W'(1);
						end
						a_q     <= qa_q;
						b_q     <= div_rsp.quotient;
						state_q <= ST_CHECK;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_dist_q <= count_q;
						out_bad_q  <= bad_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign operands.ready   = (state_q == ST_IDLE);
	assign result.valid     = out_valid_q;
	assign result.distance  = out_dist_q;
	assign result.bad_radix = out_bad_q;

`ifndef SYNTH
	a_bad_zero : assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.bad_radix |-> result.distance == '0)
		else $error("bad radix result carries a nonzero distance");

	a_dist_max : assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.distance <= DIST_W'(DATA_W))
		else $error("distance above the digit count");

	a_busy_after : assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !operands.ready)
		else $error("operand beat taken while a previous one is in work");

	a_div_owner : assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV_A || state_q == ST_DIV_B))
		else $error("divider finished outside a divide step");
`endif

endmodule
`default_nettype wire

>>> tb/base_n_digit_hamming_distance_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base_n_digit_hamming_distance_core_tb
// Drives operand pairs through the digit distance core under a range of
// radix settings, predicts each distance and error flag in a scoreboard and
// compares every result beat against it, with random idling on both sides.
// ----------------------------------------------------------------------------
module base_n_digit_hamming_distance_core_tb;
	import hdd_pkg::*;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              bad_radix;
	} dist_result_t;

	class distance_tracker;
		logic [DATA_W-1:0] radix;
		dist_result_t      pending[$];
		int unsigned       errors;
		int unsigned       beats;
		int unsigned       flagged;
		int unsigned       widest;

		function new();
			radix   = RADIX_RESET;
			errors  = 0;
			beats   = 0;
			flagged = 0;
			widest  = 0;
		endfunction

		// positions where exactly one value is still live always differ
		function dist_result_t digit_mismatches(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
			dist_result_t res;
			int unsigned  count;
			count = 0;
			if (radix < RADIX_MIN) begin
				res.distance  = '0;
				res.bad_radix = 1'b1;
				return res;
			end
			while (a != 0 || b != 0) begin
				if ((a != 0) != (b != 0)) begin
					count++;
				end else if ((a % radix) != (b % radix)) begin
					count++;
				end
				a = a / radix;
				b = b / radix;
			end
			res.distance  = DIST_W'(count);
			res.bad_radix = 1'b0;
			return res;
		endfunction

		function void note_operands(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
			dist_result_t res;
			res = digit_mismatches(a, b);
			pending.push_back(res);
			beats++;
			if (res.bad_radix) begin
				flagged++;
			end
			if (res.distance > widest) begin
				widest = res.distance;
			end
		endfunction

		function void check_result(logic [DIST_W-1:0] distance, logic bad_radix);
			dist_result_t want;
			if (pending.size() == 0) begin
				$error("result beat with nothing pending: distance %0d bad_radix %0b",
					distance, bad_radix);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (distance !== want.distance) begin
				$error("distance: expected %0d, actual %0d", want.distance, distance);
				errors++;
			end
			if (bad_radix !== want.bad_radix) begin
				$error("bad_radix: expected %0b, actual %0b", want.bad_radix, bad_radix);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              radix_we;
	logic [DATA_W-1:0] radix_wdata;
	logic              rx_stall_en;
	int unsigned       radix_writes;

	distance_tracker tracker;

	hdd_in_if  operands_bus();
	hdd_out_if result_bus();

	base_n_digit_hamming_distance_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.operands    (operands_bus),
		.result      (result_bus)
	);

	always #5 clk = ~clk;

	initial begin
		arst_n                    <= 1'b0;
		radix_we                  <= 1'b0;
		radix_wdata               <= '0;
		operands_bus.valid        <= 1'b0;
		operands_bus.first_value  <= '0;
		operands_bus.second_value <= '0;
		result_bus.ready          <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
			tracker.check_result(result_bus.distance, result_bus.bad_radix);
		end
	end

	// result side back-pressure, mostly short stalls and now and then a long one
	initial begin
		@(posedge arst_n);
		forever begin
			if (rx_stall_en && $urandom_range(0, 3) == 0) begin
				result_bus.ready <= 1'b0;
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(10, 80)) @(posedge clk);
				end else begin
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end
			end
			result_bus.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(10, 80);
	endfunction

	function automatic logic [DATA_W-1:0] pick_radix();
		case ($urandom_range(0, 9))
			0: begin
				return DATA_W'($urandom_range(0, 1));
			end
			1: begin
				return RADIX_MIN;
			end
			2: begin
				return DATA_W'($urandom_range(3, 9));
			end
			3: begin
				return RADIX_RESET;
			end
			4: begin
				return DATA_W'(16);
			end
			5: begin
				return DATA_W'($urandom_range(11, 255));
			end
			6: begin
				return DATA_W'($urandom_range(256, 65535));
			end
			7: begin
				return $urandom;
			end
			8: begin
				return 32'hFFFF_FFFF - DATA_W'($urandom_range(0, 3));
			end
			default: begin
				return 32'h8000_0000 | $urandom;
			end
		endcase
	endfunction

	task automatic pick_operands(output logic [DATA_W-1:0] a, output logic [DATA_W-1:0] b);
		int unsigned w;
		a = $urandom;
		b = $urandom;
		case ($urandom_range(0, 7))
			0: begin
			end
			1: begin
				a = DATA_W'($urandom_range(0, 999));
				b = DATA_W'($urandom_range(0, 999));
			end
			2: begin
				if ($urandom_range(0, 1) == 1) begin
					a = '0;
				end else begin
					b = '0;
				end
			end
			3: begin
				b = a;
			end
			4: begin
				b = a ^ (32'h1 << $urandom_range(0, 31));
			end
			5: begin
				// same low digit, differing higher up
				b = a + tracker.radix * DATA_W'($urandom_range(1, 5));
			end
			6: begin
				a = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : '0;
				b = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : $urandom;
			end
			default: begin
				w = $urandom_range(1, 31);
				a = a & ((32'h1 << w) - 1);
				b = b & ((32'h1 << w) - 1);
			end
		endcase
	endtask

	task automatic send_operands(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
			input int unsigned gap);
		operands_bus.valid        <= 1'b1;
		operands_bus.first_value  <= a;
		operands_bus.second_value <= b;
		do begin
			@(posedge clk);
		end while (operands_bus.ready !== 1'b1);
		tracker.note_operands(a, b);
		if (gap != 0) begin
			operands_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		operands_bus.valid <= 1'b0;
		while (tracker.pending.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_radix(input logic [DATA_W-1:0] value);
		drain();
		repeat (4) @(posedge clk);
		radix_we    <= 1'b1;
		radix_wdata <= value;
		@(posedge clk);
		radix_we      <= 1'b0;
		tracker.radix  = value;
		radix_writes++;
	endtask

	initial begin
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		int unsigned       random_beats;
		int unsigned       n;
		bit                idle_on;

		tracker      = new();
		radix_writes = 0;
		random_beats = 0;
		rx_stall_en  = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset radix of ten first, back-to-back beats
		send_operands(32'd0, 32'd0, 0);
		send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_operands(32'hFFFF_FFFF, 32'd0, 0);
		send_operands(32'd0, 32'hFFFF_FFFF, 0);
		send_operands(32'd100, 32'd0, 0);
		send_operands(32'd10, 32'd5, 0);
		send_operands(32'd12345, 32'd12045, 1);

		write_radix(RADIX_MIN);
		send_operands(32'hFFFF_FFFF, 32'd0, 0);
		send_operands(32'hAAAA_AAAA, 32'h5555_5555, 0);
		send_operands(32'h8000_0000, 32'h0000_0001, 2);

		write_radix(32'd0);
		send_operands(32'd5, 32'd7, 0);
		send_operands(32'd0, 32'd0, 0);

		write_radix(32'd1);
		send_operands(32'hFFFF_FFFF, 32'd1, 0);

		// radix of 2^32-1, which no value exceeds: two positions at most
		write_radix(32'hFFFF_FFFF);
		send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF, 0);
		send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_operands(32'd3, 32'd3, 0);
		send_operands(32'd0, 32'd7, 0);

		write_radix(32'h8000_0000);
		send_operands(32'h8000_0000, 32'h0000_0000, 0);
		send_operands(32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);

		write_radix(32'd3);
		send_operands(32'd80, 32'd26, 0);
		send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE, 0);

		while (random_beats < 520) begin
			write_radix(pick_radix());
			idle_on     = $urandom_range(0, 3) != 0;
			rx_stall_en = $urandom_range(0, 3) != 0;
			n           = $urandom_range(8, 40);
			repeat (n) begin
				pick_operands(a, b);
				send_operands(a, b, idle_on ? pick_gap() : 0);
				random_beats++;
				// hold off now and then until every result is back
				if ($urandom_range(0, 39) == 0) begin
					drain();
				end
			end
		end

		drain();
		repeat (2500) @(posedge clk);

		$display("covered %0d operand beats over %0d radix writes, radix 0 to 2^32-1",
			tracker.beats, radix_writes);
		$display("%0d beats flagged bad radix, widest distance seen %0d",
			tracker.flagged, tracker.widest);
		if (tracker.errors == 0 && tracker.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("timeout with %0d results still pending", tracker.pending.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
